>>> design/skeletal_vertex_skinning_macros.svh
// Assertion macros used by the skinning block's back part.
// Depends on nothing; the using module supplies clk and rst_n.
`ifndef SKELETAL_VERTEX_SKINNING_MACROS_SVH
`define SKELETAL_VERTEX_SKINNING_MACROS_SVH
`ifndef SYNTHESIS
`define SVS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("skinning assertion failed");
`define SVS_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("skinning assertion failed");
`else
`define SVS_ASSERT(lbl, prop)
`define SVS_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

>>> design/svs_pkg.sv
// Package of the skeletal vertex skinning block: sizes, codes and types.
// Used by every module of the block.
package svs_pkg;

    localparam int MAX_BONES   = 64;
    localparam int MAX_WEIGHTS = 1024;
    localparam int MAX_BLEND   = 16;

    localparam int SLOT_W    = 10;
    localparam int JOINT_W   = 6;
    localparam int CNT_W     = 5;
    localparam int BONE_AW   = $clog2(MAX_BONES);
    localparam int WEIGHT_AW = $clog2(MAX_WEIGHTS);
    localparam int WIDX_W    = SLOT_W + 1;

    localparam logic [1:0] FUNC_BONE   = 2'd0;
    localparam logic [1:0] FUNC_WEIGHT = 2'd1;
    localparam logic [1:0] FUNC_SKIN   = 2'd2;

    // Datapath widths of the quaternion rotation and blend.
    localparam int OPA_W  = 40;
    localparam int OPB_W  = 17;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int A_W    = 35;
    localparam int C_W    = 36;
    localparam int B_W    = 37;
    localparam int T_W    = 42;
    localparam int S_W    = 43;

    localparam int RND14_HALF = 8192;
    localparam int RND15_HALF = 16384;
    localparam int ACC_MAX    = 2147483647;
    localparam int ACC_MIN    = -2147483647 - 1;

    localparam int STEP_W    = 5;
    localparam int LAST_STEP = 18;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        CMD_BONE,
        CMD_WEIGHT,
        CMD_SKIN
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [SLOT_W-1:0]   slot;
        logic [JOINT_W-1:0]  joint;
        logic [31:0]         vx;
        logic [31:0]         vy;
        logic [31:0]         vz;
        logic [63:0]         rot;
        logic [15:0]         bias;
        logic [CNT_W-1:0]    cnt;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [63:0] rot;
    } bone_t;

    typedef struct packed {
        logic [31:0]        ox;
        logic [31:0]        oy;
        logic [31:0]        oz;
        logic [JOINT_W-1:0] joint;
        logic [15:0]        bias;
    } weight_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH_W,
        ST_FETCH_B,
        ST_MATH,
        ST_DONE
    } back_state_t;

endpackage

>>> design/skeletal_vertex_skinning.sv
// Top level of the skeletal vertex skinning block.
// Depends on svs_pkg, svs_front, svs_queue and svs_back.
//
// Input channel (in_valid / in_stall) carries one item: func 0 writes a bone
// (position and rotation quaternion), func 1 writes a weight (offset, joint,
// bias), func 2 skins one vertex from weight_count weights starting at slot.
// Only a skin item gives a result on the output channel (out_valid /
// out_stall): the blended position and a flag that tells whether any sum
// was clamped. Out-of-range writes and func 3 are dropped without a result.
// Items pass through a two-entry queue; with the back part idle, a table
// write leaves it in the cycle after it is accepted. A skin item uses at
// most 16 weights (larger counts are capped): each weight needs two table
// reads and 18 products on the one shared 40 x 17 multiplier, and the block
// skins one vertex at a time. The result sits in an output register; while
// out_stall is high it holds and the block keeps taking items until the
// queue is full.
// Reset clears the control state and the queue; the tables hold nothing
// defined until they are written.
module skeletal_vertex_skinning
    import svs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          func,
    input  logic [SLOT_W-1:0]   slot,
    input  logic [JOINT_W-1:0]  weight_bone,
    input  logic signed [31:0]  vec_x,
    input  logic signed [31:0]  vec_y,
    input  logic signed [31:0]  vec_z,
    input  logic signed [15:0]  rot_x,
    input  logic signed [15:0]  rot_y,
    input  logic signed [15:0]  rot_z,
    input  logic signed [15:0]  rot_w,
    input  logic [15:0]         bias,
    input  logic [CNT_W-1:0]    weight_count,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic signed [31:0]  pos_z,
    output logic                saturated
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    cmd_t      push_cmd;
    cmd_t      head;

    svs_front u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .slot         (slot),
        .weight_bone  (weight_bone),
        .vec_x        (vec_x),
        .vec_y        (vec_y),
        .vec_z        (vec_z),
        .rot_x        (rot_x),
        .rot_y        (rot_y),
        .rot_z        (rot_z),
        .rot_w        (rot_w),
        .bias         (bias),
        .weight_count (weight_count),
        .q_status     (q_status),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    svs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    svs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .saturated (saturated)
    );

endmodule

>>> design/svs_front.sv
// Front part: accepts input items, drops ignored ones and forms queue commands.
// Depends on svs_pkg.
module svs_front
    import svs_pkg::*;
(
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          func,
    input  logic [SLOT_W-1:0]   slot,
    input  logic [JOINT_W-1:0]  weight_bone,
    input  logic signed [31:0]  vec_x,
    input  logic signed [31:0]  vec_y,
    input  logic signed [31:0]  vec_z,
    input  logic signed [15:0]  rot_x,
    input  logic signed [15:0]  rot_y,
    input  logic signed [15:0]  rot_z,
    input  logic signed [15:0]  rot_w,
    input  logic [15:0]         bias,
    input  logic [CNT_W-1:0]    weight_count,
    input  q_status_t           q_status,
    output logic                push,
    output cmd_t                push_cmd
);

    logic keep;

    assign in_stall = q_status.full;

    always_comb
    begin
        keep          = 1'b0;
        push_cmd.kind = CMD_SKIN;
        case (func)
            FUNC_BONE:
            begin
                push_cmd.kind = CMD_BONE;
                keep          = (WIDX_W'(slot) < WIDX_W'(MAX_BONES));
            end
            FUNC_WEIGHT:
            begin
                push_cmd.kind = CMD_WEIGHT;
                keep          = (WIDX_W'(slot) < WIDX_W'(MAX_WEIGHTS));
            end
            FUNC_SKIN:
            begin
                push_cmd.kind = CMD_SKIN;
                keep          = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
        push_cmd.slot  = slot;
        push_cmd.joint = weight_bone;
        push_cmd.vx    = vec_x;
        push_cmd.vy    = vec_y;
        push_cmd.vz    = vec_z;
        push_cmd.rot   = {rot_w, rot_z, rot_y, rot_x};
        push_cmd.bias  = bias;
        push_cmd.cnt   = (weight_count > CNT_W'(MAX_BLEND)) ? CNT_W'(MAX_BLEND) : weight_count;
    end

    assign push = in_valid && !q_status.full && keep;

endmodule

>>> design/svs_queue.sv
// Short command queue between the front and back parts.
// Depends on svs_pkg.
module svs_queue
    import svs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t status
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> design/svs_back.sv
// Back part: bone and weight tables, the shared multiplier sequencer and the
// result register. Depends on svs_pkg and the assertion macro header.
`include "skeletal_vertex_skinning_macros.svh"
module svs_back
    import svs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  q_status_t          q_status,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic               saturated
);

    back_state_t state_reg;
    back_state_t state_next;

    bone_t   bone_mem [MAX_BONES];
    weight_t weight_mem [MAX_WEIGHTS];
    bone_t   b_rd_reg;
    weight_t w_rd_reg;

    logic [SLOT_W-1:0] slot_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [STEP_W-1:0] step_reg;
    logic              out_valid_reg;
    logic              sat_reg;
    logic [31:0]       pos_x_reg;
    logic [31:0]       pos_y_reg;
    logic [31:0]       pos_z_reg;
    logic              sat_out_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] tmp_reg;
    logic signed [A_W-1:0]    a_reg [3];
    logic signed [C_W-1:0]    c_reg [3];
    logic signed [OPA_W-1:0]  p_reg [3];
    logic signed [31:0]       acc_reg [3];

    logic              wr_bone;
    logic              wr_weight;
    logic              rd_w;
    logic              rd_b;
    logic              out_load;
    logic [WIDX_W-1:0] wi;
    logic              wi_bad;
    logic              cnt_done;

    logic signed [OPA_W-1:0] op_a;
    logic signed [OPB_W-1:0] op_b;
    logic signed [OPB_W-1:0] ux;
    logic signed [OPB_W-1:0] uy;
    logic signed [OPB_W-1:0] uz;
    logic signed [OPB_W-1:0] uw;
    logic signed [OPB_W-1:0] bw;
    logic signed [OPA_W-1:0] vx;
    logic signed [OPA_W-1:0] vy;
    logic signed [OPA_W-1:0] vz;

    logic signed [PROD_W:0]   diff;
    logic signed [PROD_W:0]   diff_rnd;
    logic signed [PROD_W-1:0] prod_rnd14;
    logic signed [PROD_W-1:0] prod_rnd15;
    logic signed [B_W-1:0]    b_val;
    logic signed [T_W-1:0]    t_val;
    logic [1:0]               axis;
    logic signed [OPA_W-1:0]  pos_sel;
    logic signed [OPA_W-1:0]  v_sel;
    logic signed [C_W-1:0]    c_sel;
    logic signed [OPA_W-1:0]  p_new;
    logic signed [S_W-1:0]    sum;
    logic signed [31:0]       sum_sat;
    logic                     sum_clip;

    assign wi       = WIDX_W'(slot_reg) + WIDX_W'(k_reg);
    assign wi_bad   = (wi >= WIDX_W'(MAX_WEIGHTS));
    assign cnt_done = (k_reg == cnt_reg);
    assign out_load = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty && (cmd.kind == CMD_SKIN))
                begin
                    state_next = ST_FETCH_W;
                end
            end
            ST_FETCH_W:
            begin
                if (cnt_done)
                begin
                    state_next = ST_DONE;
                end
                else if (!wi_bad)
                begin
                    state_next = ST_FETCH_B;
                end
            end
            ST_FETCH_B:
            begin
                state_next = ST_MATH;
            end
            ST_MATH:
            begin
                if (step_reg == STEP_W'(LAST_STEP))
                begin
                    state_next = ST_FETCH_W;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        pop       = 1'b0;
        wr_bone   = 1'b0;
        wr_weight = 1'b0;
        rd_w      = 1'b0;
        rd_b      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pop       = !q_status.empty;
                wr_bone   = !q_status.empty && (cmd.kind == CMD_BONE);
                wr_weight = !q_status.empty && (cmd.kind == CMD_WEIGHT);
            end
            ST_FETCH_W:
            begin
                rd_w = !cnt_done && !wi_bad;
            end
            ST_FETCH_B:
            begin
                rd_b = 1'b1;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Tables.
    always_ff @(posedge clk)
    begin
        if (wr_bone)
        begin
            bone_mem[cmd.slot[BONE_AW-1:0]] <= '{px: cmd.vx, py: cmd.vy, pz: cmd.vz,
                                                  rot: cmd.rot};
        end
        if (rd_b)
        begin
            b_rd_reg <= bone_mem[w_rd_reg.joint[BONE_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_weight)
        begin
            weight_mem[cmd.slot[WEIGHT_AW-1:0]] <= '{ox: cmd.vx, oy: cmd.vy, oz: cmd.vz,
                                                      joint: cmd.joint, bias: cmd.bias};
        end
        if (rd_w)
        begin
            w_rd_reg <= weight_mem[wi[WEIGHT_AW-1:0]];
        end
    end

    assign ux = OPB_W'($signed(b_rd_reg.rot[15:0]));
    assign uy = OPB_W'($signed(b_rd_reg.rot[31:16]));
    assign uz = OPB_W'($signed(b_rd_reg.rot[47:32]));
    assign uw = OPB_W'($signed(b_rd_reg.rot[63:48]));
    assign bw = $signed({1'b0, w_rd_reg.bias});
    assign vx = OPA_W'($signed(w_rd_reg.ox));
    assign vy = OPA_W'($signed(w_rd_reg.oy));
    assign vz = OPA_W'($signed(w_rd_reg.oz));

    // Operands issued to the multiplier at each step. The cross products
    // come first, then the w terms, then the second cross products and the
    // bias scaling, so every operand is ready when its step comes up.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (step_reg)
            5'd0:    begin op_a = vz;                op_b = uy; end
            5'd1:    begin op_a = vy;                op_b = uz; end
            5'd2:    begin op_a = vx;                op_b = uz; end
            5'd3:    begin op_a = vz;                op_b = ux; end
            5'd4:    begin op_a = vy;                op_b = ux; end
            5'd5:    begin op_a = vx;                op_b = uy; end
            5'd6:    begin op_a = OPA_W'(a_reg[0]); op_b = uw; end
            5'd7:    begin op_a = OPA_W'(a_reg[1]); op_b = uw; end
            5'd8:    begin op_a = OPA_W'(a_reg[2]); op_b = uw; end
            5'd9:    begin op_a = OPA_W'(a_reg[2]); op_b = uy; end
            5'd10:   begin op_a = OPA_W'(a_reg[1]); op_b = uz; end
            5'd11:   begin op_a = OPA_W'(a_reg[0]); op_b = uz; end
            5'd12:   begin op_a = OPA_W'(a_reg[2]); op_b = ux; end
            5'd13:   begin op_a = OPA_W'(a_reg[1]); op_b = ux; end
            5'd14:   begin op_a = OPA_W'(a_reg[0]); op_b = uy; end
            5'd15:   begin op_a = p_reg[0];         op_b = bw; end
            5'd16:   begin op_a = p_reg[1];         op_b = bw; end
            5'd17:   begin op_a = p_reg[2];         op_b = bw; end
            default: begin op_a = '0;               op_b = '0; end
        endcase
    end

    assign diff       = (PROD_W + 1)'(tmp_reg) - (PROD_W + 1)'(prod_reg);
    assign diff_rnd   = (diff + (PROD_W + 1)'(RND14_HALF)) >>> 14;
    assign prod_rnd14 = (prod_reg + PROD_W'(RND14_HALF)) >>> 14;
    assign prod_rnd15 = (prod_reg + PROD_W'(RND15_HALF)) >>> 15;
    assign b_val      = B_W'(diff_rnd);
    assign t_val      = T_W'(prod_rnd15);

    always_comb
    begin
        case (step_reg)
            5'd11, 5'd16: axis = 2'd0;
            5'd13, 5'd17: axis = 2'd1;
            5'd15, 5'd18: axis = 2'd2;
            default:      axis = 2'd0;
        endcase
        case (axis)
            2'd0:    begin pos_sel = OPA_W'($signed(b_rd_reg.px)); v_sel = vx; end
            2'd1:    begin pos_sel = OPA_W'($signed(b_rd_reg.py)); v_sel = vy; end
            default: begin pos_sel = OPA_W'($signed(b_rd_reg.pz)); v_sel = vz; end
        endcase
        c_sel = c_reg[axis];
        p_new = pos_sel + v_sel + ((OPA_W'(c_sel) + OPA_W'(b_val)) <<< 1);
        sum   = S_W'(acc_reg[axis]) + S_W'(t_val);
        if (sum > S_W'(ACC_MAX))
        begin
            sum_sat  = 32'(ACC_MAX);
            sum_clip = 1'b1;
        end
        else if (sum < S_W'(ACC_MIN))
        begin
            sum_sat  = 32'(ACC_MIN);
            sum_clip = 1'b1;
        end
        else
        begin
            sum_sat  = 32'(sum);
            sum_clip = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            cnt_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE)
            begin
                k_reg   <= '0;
                cnt_reg <= cmd.cnt;
            end
            else if ((state_reg == ST_FETCH_W) && !cnt_done && wi_bad)
            begin
                k_reg <= k_reg + CNT_W'(1);
            end
            else if ((state_reg == ST_MATH) && (step_reg == STEP_W'(LAST_STEP)))
            begin
                k_reg <= k_reg + CNT_W'(1);
            end
            if (state_reg == ST_MATH)
            begin
                step_reg <= (step_reg == STEP_W'(LAST_STEP)) ? '0 : step_reg + STEP_W'(1);
            end
            else
            begin
                step_reg <= '0;
            end
            if ((state_reg == ST_DONE) && out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers; the product of step k is consumed at step k + 1.
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        if (state_reg == ST_IDLE)
        begin
            slot_reg   <= cmd.slot;
            sat_reg    <= 1'b0;
            acc_reg[0] <= '0;
            acc_reg[1] <= '0;
            acc_reg[2] <= '0;
        end
        if (state_reg == ST_MATH)
        begin
            case (step_reg)
                5'd1, 5'd3, 5'd5, 5'd10, 5'd12, 5'd14: tmp_reg <= prod_reg;
                5'd2:  a_reg[0] <= A_W'(diff_rnd);
                5'd4:  a_reg[1] <= A_W'(diff_rnd);
                5'd6:  a_reg[2] <= A_W'(diff_rnd);
                5'd7:  c_reg[0] <= C_W'(prod_rnd14);
                5'd8:  c_reg[1] <= C_W'(prod_rnd14);
                5'd9:  c_reg[2] <= C_W'(prod_rnd14);
                5'd11: p_reg[0] <= p_new;
                5'd13: p_reg[1] <= p_new;
                5'd15: p_reg[2] <= p_new;
                5'd16, 5'd17, 5'd18:
                begin
                    acc_reg[axis] <= sum_sat;
                    sat_reg       <= sat_reg | sum_clip;
                end
                default:
                begin
                    tmp_reg <= tmp_reg;
                end
            endcase
        end
        if ((state_reg == ST_DONE) && out_load)
        begin
            pos_x_reg   <= acc_reg[0];
            pos_y_reg   <= acc_reg[1];
            pos_z_reg   <= acc_reg[2];
            sat_out_reg <= sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = $signed(pos_x_reg);
    assign pos_y     = $signed(pos_y_reg);
    assign pos_z     = $signed(pos_z_reg);
    assign saturated = sat_out_reg;

    `SVS_ASSERT(a_step_range, (state_reg != ST_MATH) || (step_reg <= STEP_W'(LAST_STEP)))
    `SVS_ASSERT(a_pop_idle, !pop || (state_reg == ST_IDLE))
    `SVS_ASSERT(a_k_bound, (state_reg == ST_IDLE) || (k_reg <= cnt_reg))
    `SVS_ASSERT_NEXT(a_done_load, (state_reg == ST_DONE) && out_load, out_valid_reg && (state_reg == ST_IDLE))

endmodule
